// File: src/nnsi_pkg.sv
// Shared types and constants for the nearest-neighbour swap inserter.
package nnsi_pkg;

  localparam int QUBIT_COUNT = 32;
  localparam int QIDX_W      = 5;
  localparam int TAG_W       = 16;
  localparam int CNT_W       = 3;
  localparam int STATE_W     = 3;

  localparam logic [CNT_W-1:0]  TWO_OPERANDS = CNT_W'(2);
  // One bit wider than an index so that the device size itself fits.
  localparam logic [QIDX_W:0]   QUBIT_LIMIT  = (QIDX_W+1)'(QUBIT_COUNT);

  typedef logic [QIDX_W-1:0] qidx_t;

  // Request to the shared step unit.
  typedef struct packed {
    qidx_t operand;   // index to move by one place
    logic  up;        // 1: add one, 0: subtract one
    qidx_t gap;       // current distance between the moving qubits
    qidx_t span_max;  // effective maximum distance
    qidx_t target;    // original index a backward walk stops at
  } alu_req_t;

  // Answer of the shared step unit.
  typedef struct packed {
    qidx_t stepped;  // operand moved by one place
    qidx_t gap_dec;  // gap after one more forward swap
    logic  fits;     // reduced gap is within the maximum distance
    logic  hit;      // stepped index reached the target
  } alu_rsp_t;

endpackage

// File: src/nearest_neighbor_swap_inserter_unit.sv
// Top level of the nearest-neighbour swap inserter: distance register, sequencer, checks.
// The first result beat enters the output register after the gate is captured in the
// sequencer state, once the output is not stalled. Results leave one per cycle while the
// output is not stalled, from a single shared one-place step unit under the sequencer;
// the input stays stalled until the last result of the gate is registered.
// Reset (rst, synchronous, active high): sequencer idle, output empty, max_distance = 1.
// A max_distance of 0 acts as 1.
module nearest_neighbor_swap_inserter_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: max_distance
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  nnsi_pkg::qidx_t             cfg_data,
  // gate input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nnsi_pkg::TAG_W-1:0]  gate_tag,
  input  logic [nnsi_pkg::CNT_W-1:0]  operand_count,
  input  nnsi_pkg::qidx_t             qubit_first,
  input  nnsi_pkg::qidx_t             qubit_second,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_swap,
  output logic [nnsi_pkg::TAG_W-1:0]  out_tag,
  output nnsi_pkg::qidx_t             out_first,
  output nnsi_pkg::qidx_t             out_second,
  output logic                        last_of_run
);
  import nnsi_pkg::*;

  qidx_t max_distance;

  // Writes must arrive only while idle; the block does not enforce this and accepts every beat at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance <= qidx_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      max_distance <= cfg_data;
    end
  end

  // The sequencer snapshots the distance when a gate is accepted and then steps lower/upper
  // qubits in turn (or passes the gate through), one beat per cycle while the output is not stalled.
  nnsi_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .max_dist      (max_distance),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .gate_tag      (gate_tag),
    .operand_count (operand_count),
    .qubit_first   (qubit_first),
    .qubit_second  (qubit_second),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_swap       (is_swap),
    .out_tag       (out_tag),
    .out_first     (out_first),
    .out_second    (out_second),
    .last_of_run   (last_of_run)
  );

`ifndef SYNTH
  // An accepted gate closes the input in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held after gate accepted");

  // Every inserted swap acts on neighbouring qubits.
  a_swap_adjacent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_swap) |->
      ((out_first == out_second + 1) || (out_second == out_first + 1)))
    else $error("swap on non-adjacent qubits");

  // The input reopens only once the final beat of the run is in the output register.
  a_reopen_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(in_stall) && !$past(rst)) |-> (out_valid && last_of_run))
    else $error("input reopened before run finished");
`endif

endmodule

// File: src/nnsi_alu.sv
// Shared step unit: one-place qubit move, gap update and stop checks.
module nnsi_alu (
  input  nnsi_pkg::alu_req_t req,
  output nnsi_pkg::alu_rsp_t rsp
);
  import nnsi_pkg::*;

  always_comb begin
    rsp.stepped = req.up ? (req.operand + qidx_t'(1)) : (req.operand - qidx_t'(1));
    rsp.gap_dec = req.gap - qidx_t'(1);
    rsp.fits    = (rsp.gap_dec <= req.span_max);
    rsp.hit     = (rsp.stepped == req.target);
  end

endmodule

// File: src/nnsi_seq.sv
// Sequencer: captures one gate, walks it through the step unit when swaps are needed, registers each result beat.
module nnsi_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  nnsi_pkg::qidx_t             max_dist,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [nnsi_pkg::TAG_W-1:0]  gate_tag,
  input  logic [nnsi_pkg::CNT_W-1:0]  operand_count,
  input  nnsi_pkg::qidx_t             qubit_first,
  input  nnsi_pkg::qidx_t             qubit_second,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_swap,
  output logic [nnsi_pkg::TAG_W-1:0]  out_tag,
  output nnsi_pkg::qidx_t             out_first,
  output nnsi_pkg::qidx_t             out_second,
  output logic                        last_of_run
);
  import nnsi_pkg::*;

  localparam logic [STATE_W-1:0] S_IDLE    = 3'd0;
  localparam logic [STATE_W-1:0] S_PASS    = 3'd1;
  localparam logic [STATE_W-1:0] S_FWD_LO  = 3'd2;
  localparam logic [STATE_W-1:0] S_FWD_HI  = 3'd3;
  localparam logic [STATE_W-1:0] S_GATE    = 3'd4;
  localparam logic [STATE_W-1:0] S_BACK_LO = 3'd5;
  localparam logic [STATE_W-1:0] S_BACK_HI = 3'd6;

  logic [STATE_W-1:0] state, state_next;
  qidx_t              lo, lo_next, hi, hi_next, olo, olo_next, ohi, ohi_next;
  qidx_t              cur, cur_next, gap, gap_next, span_max, span_max_next;
  logic               rev, rev_next;
  logic [TAG_W-1:0]   tag, tag_next;
  logic               out_valid_next, is_swap_next, last_next;
  logic [TAG_W-1:0]   out_tag_next;
  qidx_t              out_first_next, out_second_next;

  logic               adv;
  logic               pass;
  qidx_t              cap_lo, cap_hi, cap_dist;
  alu_req_t           req;
  alu_rsp_t           rsp;

  nnsi_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign in_stall = (state != S_IDLE);
  // Output register is free, or its beat leaves this cycle.
  assign adv = !out_valid || !out_stall;

  always_comb begin
    cap_lo   = (qubit_first < qubit_second) ? qubit_first  : qubit_second;
    cap_hi   = (qubit_first < qubit_second) ? qubit_second : qubit_first;
    cap_dist = (max_dist == qidx_t'(0)) ? qidx_t'(1) : max_dist;
    pass     = (operand_count != TWO_OPERANDS)
            || ({1'b0, qubit_first}  >= QUBIT_LIMIT)
            || ({1'b0, qubit_second} >= QUBIT_LIMIT)
            || ((cap_hi - cap_lo) <= cap_dist);
  end

  always_comb begin
    req.gap      = gap;
    req.span_max = span_max;
    unique case (state)
      S_FWD_LO: begin
        req.operand = lo;
        req.up      = 1'b1;
        req.target  = olo;
      end
      S_FWD_HI: begin
        req.operand = hi;
        req.up      = 1'b0;
        req.target  = ohi;
      end
      S_BACK_LO: begin
        req.operand = cur;
        req.up      = 1'b0;
        req.target  = olo;
      end
      S_BACK_HI: begin
        req.operand = cur;
        req.up      = 1'b1;
        req.target  = ohi;
      end
      default: begin
        req.operand = cur;
        req.up      = 1'b1;
        req.target  = ohi;
      end
    endcase
  end

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    olo_next        = olo;
    ohi_next        = ohi;
    cur_next        = cur;
    gap_next        = gap;
    span_max_next   = span_max;
    rev_next        = rev;
    tag_next        = tag;
    out_valid_next  = adv ? 1'b0 : out_valid;
    is_swap_next    = is_swap;
    out_tag_next    = out_tag;
    out_first_next  = out_first;
    out_second_next = out_second;
    last_next       = last_of_run;

    if (state == S_IDLE) begin
      if (in_valid) begin
        tag_next      = gate_tag;
        span_max_next = cap_dist;
        rev_next      = (qubit_first > qubit_second);
        olo_next      = cap_lo;
        ohi_next      = cap_hi;
        gap_next      = cap_hi - cap_lo;
        if (pass) begin
          // keep operands as they arrived
          lo_next    = qubit_first;
          hi_next    = qubit_second;
          state_next = S_PASS;
        end else begin
          lo_next    = cap_lo;
          hi_next    = cap_hi;
          state_next = S_FWD_LO;
        end
      end
    end else if (adv) begin
      out_valid_next = 1'b1;
      out_tag_next   = tag;
      is_swap_next   = 1'b1;
      last_next      = 1'b0;
      unique case (state)
        S_PASS: begin
          is_swap_next    = 1'b0;
          out_first_next  = lo;
          out_second_next = hi;
          last_next       = 1'b1;
          state_next      = S_IDLE;
        end
        S_FWD_LO: begin
          out_first_next  = lo;
          out_second_next = rsp.stepped;
          lo_next         = rsp.stepped;
          gap_next        = rsp.gap_dec;
          state_next      = rsp.fits ? S_GATE : S_FWD_HI;
        end
        S_FWD_HI: begin
          out_first_next  = hi;
          out_second_next = rsp.stepped;
          hi_next         = rsp.stepped;
          gap_next        = rsp.gap_dec;
          state_next      = rsp.fits ? S_GATE : S_FWD_LO;
        end
        S_GATE: begin
          // lower side always moved at least once, so a backward walk follows
          is_swap_next    = 1'b0;
          out_first_next  = rev ? hi : lo;
          out_second_next = rev ? lo : hi;
          cur_next        = lo;
          state_next      = S_BACK_LO;
        end
        S_BACK_LO: begin
          out_first_next  = cur;
          out_second_next = rsp.stepped;
          cur_next        = rsp.stepped;
          if (rsp.hit) begin
            if (hi != ohi) begin
              cur_next   = hi;
              state_next = S_BACK_HI;
            end else begin
              last_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
        S_BACK_HI: begin
          out_first_next  = cur;
          out_second_next = rsp.stepped;
          cur_next        = rsp.stepped;
          if (rsp.hit) begin
            last_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
        default: begin
          out_valid_next = 1'b0;
          state_next     = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo          <= lo_next;
    hi          <= hi_next;
    olo         <= olo_next;
    ohi         <= ohi_next;
    cur         <= cur_next;
    gap         <= gap_next;
    span_max    <= span_max_next;
    rev         <= rev_next;
    tag         <= tag_next;
    is_swap     <= is_swap_next;
    out_tag     <= out_tag_next;
    out_first   <= out_first_next;
    out_second  <= out_second_next;
    last_of_run <= last_next;
  end

endmodule
